@@ rtl/core/lrpp_pkg.sv @@
// Shared types and constants for the looping play position block.
// No dependencies; imported by the stream interface and the top level.
`default_nettype none

package lrpp_pkg;

  localparam int unsigned POS_W   = 31;
  localparam int unsigned DELTA_W = 21;
  localparam int unsigned RATE_W  = 16;
  localparam int unsigned RATE_FRAC_BITS = 8;
  localparam int unsigned PROD_W  = DELTA_W + RATE_W;
  localparam int unsigned DIV_W   = 32;

  localparam logic [15:0] EPSILON_UNITS = 16'd7;
  localparam logic [RATE_W-1:0] RATE_RESET = 16'sd256;

  localparam int unsigned APB_ADDR_W = 5;
  localparam int unsigned APB_DATA_W = 32;

  localparam logic [2:0] REG_PRESENT = 3'd0;
  localparam logic [2:0] REG_LENGTH  = 3'd1;
  localparam logic [2:0] REG_START   = 3'd2;
  localparam logic [2:0] REG_END     = 3'd3;
  localparam logic [2:0] REG_RATE    = 3'd4;
  localparam logic [2:0] REG_LOOPING = 3'd5;

  localparam logic ACT_ADVANCE = 1'b0;
  localparam logic ACT_RESTART = 1'b1;

  typedef struct packed {
    logic               action;
    logic [DELTA_W-1:0] delta_time;
  } lrpp_in_t;

  typedef struct packed {
    logic [POS_W-1:0] previous_position;
    logic [POS_W-1:0] new_position;
    logic             wrapped_forward;
    logic             wrapped_backward;
    logic [POS_W-1:0] effective_start;
    logic [POS_W-1:0] effective_end;
    logic [POS_W-1:0] elapsed_in_range;
    logic [POS_W-1:0] remaining_in_range;
  } lrpp_out_t;

endpackage

`default_nettype wire

@@ rtl/core/lrpp_stream_if.sv @@
// Valid/ready stream channel carrying one beat of payload type T.
// Depends on lrpp_pkg for the default payload type.
`default_nettype none

interface lrpp_stream_if
  import lrpp_pkg::*;
#(
  parameter type T = lrpp_in_t
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

@@ rtl/core/loop_range_play_position.sv @@
// Looping play position with loop points: top level, APB config and datapath.
// Depends on lrpp_pkg and lrpp_stream_if.
//
// Usage:
//   in_i carries one beat per tick: action (advance or restart) and delta_time.
//   out_o returns exactly one beat per input beat, in order.
//   The user must write registers over the APB port only while the block
//   is idle; the block itself does not enforce this.
// Sequence from accept to out_o.valid: restart, no sequence, zero length or
//   narrow range go straight to clamp; a clamping advance also runs the
//   shift-add multiplier (one delta bit per cycle), and a wrapping advance
//   also the restoring remainder unit (one dividend bit per cycle).
// Throughput: one item at a time; in_i.ready is high only when the sequencer
//   is idle, so a next beat can be taken in the cycle after the result loads.
// Output: a result register holds the beat; a new beat is accepted while it
//   waits, and the finished next result waits until out_o.ready takes the old.
// Reset (rst_ni low): position 0, play_rate 1.0, other config registers 0,
//   output register empty.
`default_nettype none

module loop_range_play_position
  import lrpp_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  lrpp_stream_if.sink                in_i,
  lrpp_stream_if.source              out_o,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [APB_ADDR_W-1:0] paddr,
  input  wire logic [APB_DATA_W-1:0] pwdata,
  output logic      [APB_DATA_W-1:0] prdata,
  output logic                       pready
);

  localparam logic [3:0] ST_IDLE   = 4'd0;
  localparam logic [3:0] ST_START  = 4'd1;
  localparam logic [3:0] ST_ENDR   = 4'd2;
  localparam logic [3:0] ST_SPAN   = 4'd3;
  localparam logic [3:0] ST_DECIDE = 4'd4;
  localparam logic [3:0] ST_MUL    = 4'd5;
  localparam logic [3:0] ST_RAW    = 4'd6;
  localparam logic [3:0] ST_LOOP   = 4'd7;
  localparam logic [3:0] ST_DIV    = 4'd8;
  localparam logic [3:0] ST_MODFIX = 4'd9;
  localparam logic [3:0] ST_POSW   = 4'd10;
  localparam logic [3:0] ST_CLAMP  = 4'd11;
  localparam logic [3:0] ST_ELAP   = 4'd12;
  localparam logic [3:0] ST_OUT    = 4'd13;

  localparam int unsigned CNT_W = $clog2(DIV_W + 1);
  localparam logic [CNT_W-1:0] MUL_LAST = CNT_W'(DELTA_W - 1);
  localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(DIV_W - 1);

  // configuration
  logic              present_q;
  logic [POS_W-1:0]  length_q, rstart_q, rend_q;
  logic [RATE_W-1:0] rate_q;
  logic              loop_q;
  logic              wr_en;

  // control state
  logic [3:0]        state_q, state_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [POS_W-1:0]  pos_q, pos_d;
  logic              out_valid_q, out_valid_d;

  // payload
  logic                action_q, action_d;
  logic [POS_W-1:0]    s_q, s_d, e_q, e_d, span_q, span_d, prev_q, prev_d;
  logic [PROD_W-1:0]   acc_q, acc_d;
  logic signed [32:0]  raw_q, raw_d;
  logic                xneg_q, xneg_d;
  logic [DIV_W-1:0]    dv_q, dv_d;
  logic [POS_W-1:0]    rem_q, rem_d;
  logic                fwd_q, fwd_d, bwd_q, bwd_d;
  logic [POS_W-1:0]    posc_q, posc_d, elap_q, elap_d;
  lrpp_out_t           out_q, out_d;

  // datapath helpers
  logic [RATE_W-1:0]   mag;
  logic                rate_neg, rate_pos, wide;
  logic [31:0]         eps_lim;
  logic [16:0]         mul_sum;
  logic signed [32:0]  prev_ext, d_ext, s_ext, e_ext, x_up, x_dn;
  logic [31:0]         div_t, div_sub;
  logic                div_ge;
  logic                out_free;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      present_q <= 1'b0;
      length_q  <= '0;
      rstart_q  <= '0;
      rend_q    <= '0;
      rate_q    <= RATE_RESET;
      loop_q    <= 1'b0;
    end else if (wr_en) begin
      unique case (paddr[4:2])
        REG_PRESENT: present_q <= pwdata[0];
        REG_LENGTH:  length_q  <= pwdata[POS_W-1:0];
        REG_START:   rstart_q  <= pwdata[POS_W-1:0];
        REG_END:     rend_q    <= pwdata[POS_W-1:0];
        REG_RATE:    rate_q    <= pwdata[RATE_W-1:0];
        REG_LOOPING: loop_q    <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[4:2])
      REG_PRESENT: prdata = {31'b0, present_q};
      REG_LENGTH:  prdata = {1'b0, length_q};
      REG_START:   prdata = {1'b0, rstart_q};
      REG_END:     prdata = {1'b0, rend_q};
      REG_RATE:    prdata = {16'b0, rate_q};
      REG_LOOPING: prdata = {31'b0, loop_q};
      default:     prdata = '0;
    endcase
  end

  assign rate_neg = rate_q[RATE_W-1];
  assign rate_pos = !rate_neg && (rate_q != '0);
  assign mag      = rate_neg ? (~rate_q + 16'd1) : rate_q;
  assign wide     = span_q > {15'b0, EPSILON_UNITS};
  assign eps_lim  = {1'b0, s_q} + {16'b0, EPSILON_UNITS};
  assign mul_sum  = {1'b0, acc_q[PROD_W-1:DELTA_W]} + (acc_q[0] ? {1'b0, mag} : 17'd0);
  assign prev_ext = signed'({2'b00, prev_q});
  assign d_ext    = signed'({4'b0000, acc_q[PROD_W-1:RATE_FRAC_BITS]});
  assign s_ext    = signed'({2'b00, s_q});
  assign e_ext    = signed'({2'b00, e_q});
  assign x_up     = raw_q - s_ext;
  assign x_dn     = s_ext - raw_q;
  assign div_t    = {rem_q, dv_q[DIV_W-1]};
  assign div_ge   = div_t >= {1'b0, span_q};
  assign div_sub  = div_t - {1'b0, span_q};
  assign out_free = !out_valid_q || out_o.ready;

  assign in_i.ready  = (state_q == ST_IDLE);
  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_q;

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    pos_d       = pos_q;
    out_valid_d = out_valid_q && !out_o.ready;
    action_d    = action_q;
    s_d         = s_q;
    e_d         = e_q;
    span_d      = span_q;
    prev_d      = prev_q;
    acc_d       = acc_q;
    raw_d       = raw_q;
    xneg_d      = xneg_q;
    dv_d        = dv_q;
    rem_d       = rem_q;
    fwd_d       = fwd_q;
    bwd_d       = bwd_q;
    posc_d      = posc_q;
    elap_d      = elap_q;
    out_d       = out_q;

    unique case (state_q)
      ST_IDLE: begin
        if (in_i.valid) begin
          action_d = in_i.data.action;
          acc_d    = {16'b0, in_i.data.delta_time};
          fwd_d    = 1'b0;
          bwd_d    = 1'b0;
          state_d  = ST_START;
        end
      end
      ST_START: begin
        s_d     = !present_q ? '0 : (rstart_q < length_q ? rstart_q : length_q);
        state_d = ST_ENDR;
      end
      ST_ENDR: begin
        if (!present_q) e_d = '0;
        else if ({1'b0, rend_q} <= eps_lim) e_d = length_q;
        else e_d = (rend_q < length_q) ? rend_q : length_q;
        state_d = ST_SPAN;
      end
      ST_SPAN: begin
        span_d  = e_q - s_q;
        prev_d  = (pos_q < s_q) ? s_q : ((pos_q > e_q) ? e_q : pos_q);
        state_d = ST_DECIDE;
      end
      ST_DECIDE: begin
        state_d = ST_CLAMP;
        priority if (action_q == ACT_RESTART) begin
          pos_d = (rate_neg && wide) ? e_q : s_q;
        end else if (!present_q || length_q == '0) begin
          pos_d = '0;
        end else if (!wide) begin
          pos_d = s_q;
        end else begin
          cnt_d   = MUL_LAST;
          state_d = ST_MUL;
        end
      end
      ST_MUL: begin
        acc_d = {mul_sum, acc_q[DELTA_W-1:1]};
        cnt_d = cnt_q - 1'b1;
        if (cnt_q == '0) state_d = ST_RAW;
      end
      ST_RAW: begin
        raw_d   = rate_neg ? (prev_ext - d_ext) : (prev_ext + d_ext);
        state_d = ST_LOOP;
      end
      ST_LOOP: begin
        if (loop_q) begin
          fwd_d   = rate_pos && (raw_q >= e_ext);
          bwd_d   = rate_neg && (raw_q < s_ext);
          xneg_d  = raw_q < s_ext;
          dv_d    = (raw_q < s_ext) ? x_dn[DIV_W-1:0] : x_up[DIV_W-1:0];
          rem_d   = '0;
          cnt_d   = DIV_LAST;
          state_d = ST_DIV;
        end else begin
          if (raw_q < s_ext) pos_d = s_q;
          else if (raw_q > e_ext) pos_d = e_q;
          else pos_d = raw_q[POS_W-1:0];
          state_d = ST_CLAMP;
        end
      end
      ST_DIV: begin
        rem_d = div_ge ? div_sub[POS_W-1:0] : div_t[POS_W-1:0];
        dv_d  = {dv_q[DIV_W-2:0], 1'b0};
        cnt_d = cnt_q - 1'b1;
        if (cnt_q == '0) state_d = ST_MODFIX;
      end
      ST_MODFIX: begin
        // negative offset folds back from the top of the range
        if (xneg_q && rem_q != '0) rem_d = span_q - rem_q;
        state_d = ST_POSW;
      end
      ST_POSW: begin
        pos_d   = s_q + rem_q;
        state_d = ST_CLAMP;
      end
      ST_CLAMP: begin
        posc_d  = (pos_q < s_q) ? s_q : ((pos_q > e_q) ? e_q : pos_q);
        state_d = ST_ELAP;
      end
      ST_ELAP: begin
        elap_d  = posc_q - s_q;
        state_d = ST_OUT;
      end
      ST_OUT: begin
        if (out_free) begin
          out_d.previous_position  = prev_q;
          out_d.new_position       = pos_q;
          out_d.wrapped_forward    = fwd_q;
          out_d.wrapped_backward   = bwd_q;
          out_d.effective_start    = s_q;
          out_d.effective_end      = e_q;
          out_d.elapsed_in_range   = elap_q;
          out_d.remaining_in_range = span_q - elap_q;
          out_valid_d              = 1'b1;
          state_d                  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      pos_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      pos_q       <= pos_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    action_q <= action_d;
    s_q      <= s_d;
    e_q      <= e_d;
    span_q   <= span_d;
    prev_q   <= prev_d;
    acc_q    <= acc_d;
    raw_q    <= raw_d;
    xneg_q   <= xneg_d;
    dv_q     <= dv_d;
    rem_q    <= rem_d;
    fwd_q    <= fwd_d;
    bwd_q    <= bwd_d;
    posc_q   <= posc_d;
    elap_q   <= elap_d;
    out_q    <= out_d;
  end

endmodule

`default_nettype wire

@@ tb/loop_range_play_position_tb.sv @@
// Self-checking testbench for loop_range_play_position: directed table, then random phases.
// Depends on lrpp_pkg, lrpp_stream_if and the loop_range_play_position RTL.
// Results are checked field by field against an in-bench predictor or known table values.
module loop_range_play_position_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import lrpp_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 400000;
  localparam int unsigned DRAIN_CYCLES = 70;
  localparam int unsigned RAND_PHASES  = 20;
  localparam int unsigned PHASE_BEATS  = 25;
  localparam int unsigned DIR_N        = 41;
  localparam logic [POS_W-1:0] POS_MAX = 31'h7FFF_FFFF;
  localparam lrpp_out_t ZERO_RES       = '0;

  typedef struct {
    bit                 cfg;
    logic [2:0]         reg_idx;
    logic [31:0]        wdata;
    logic               act;
    logic [DELTA_W-1:0] dt;
    bit                 known;
    lrpp_out_t          res;
  } dir_row_t;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  lrpp_stream_if #(.T(lrpp_in_t))  in_if ();
  lrpp_stream_if #(.T(lrpp_out_t)) out_if ();

  loop_range_play_position u_top (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_if),
    .out_o   (out_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // predictor copy of the registers and the play position
  logic                     cfg_present;
  logic [POS_W-1:0]         cfg_length;
  logic [POS_W-1:0]         cfg_start;
  logic [POS_W-1:0]         cfg_end;
  logic signed [RATE_W-1:0] cfg_rate;
  logic                     cfg_looping;
  logic [POS_W-1:0]         play_pos;

  lrpp_out_t   pending_results[$];
  dir_row_t    dir_tab [DIR_N];
  bit          no_gaps;
  int unsigned err_count;
  int unsigned cycle_count;
  int unsigned beats_sent;
  int unsigned restarts_sent;
  int unsigned settings_done;
  int unsigned fwd_wraps;
  int unsigned bwd_wraps;

  always #1 clk_i = ~clk_i;

  function automatic int unsigned pick_wait();
    return no_gaps ? 0 : $urandom_range(0, 14);
  endfunction

  function automatic lrpp_out_t mk_res(input logic [POS_W-1:0] prev, input logic [POS_W-1:0] nw,
                                       input logic [POS_W-1:0] s, input logic [POS_W-1:0] e,
                                       input logic [POS_W-1:0] el, input logic [POS_W-1:0] rem);
    lrpp_out_t r;
    r = '0;
    r.previous_position  = prev;
    r.new_position       = nw;
    r.effective_start    = s;
    r.effective_end      = e;
    r.elapsed_in_range   = el;
    r.remaining_in_range = rem;
    return r;
  endfunction

  function automatic dir_row_t cfg_row(input logic [2:0] idx, input logic [31:0] v);
    dir_row_t row;
    row = '{cfg: 1'b1, reg_idx: idx, wdata: v, act: ACT_ADVANCE, dt: '0, known: 1'b0,
            res: ZERO_RES};
    return row;
  endfunction

  function automatic dir_row_t beat_row(input logic act, input logic [DELTA_W-1:0] dt);
    dir_row_t row;
    row = '{cfg: 1'b0, reg_idx: REG_PRESENT, wdata: '0, act: act, dt: dt, known: 1'b0,
            res: ZERO_RES};
    return row;
  endfunction

  function automatic dir_row_t known_row(input logic act, input logic [DELTA_W-1:0] dt,
                                         input lrpp_out_t r);
    dir_row_t row;
    row = beat_row(act, dt);
    row.known = 1'b1;
    row.res = r;
    return row;
  endfunction

  function automatic void apply_reg(input logic [2:0] idx, input logic [31:0] v);
    case (idx)
      REG_PRESENT: cfg_present = v[0];
      REG_LENGTH:  cfg_length  = v[POS_W-1:0];
      REG_START:   cfg_start   = v[POS_W-1:0];
      REG_END:     cfg_end     = v[POS_W-1:0];
      REG_RATE:    cfg_rate    = v[RATE_W-1:0];
      REG_LOOPING: cfg_looping = v[0];
      default: ;
    endcase
  endfunction

  // one tick of the play position; updates play_pos and returns the result beat
  function automatic lrpp_out_t step_play_position(input logic act,
                                                   input logic [DELTA_W-1:0] dt);
    longint s, e, span, eps, prev, mag, d, raw, off, nxt, el, rem;
    lrpp_out_t r;
    r = '0;
    eps = longint'(EPSILON_UNITS);
    s = 0;
    e = 0;
    if (cfg_present) begin
      s = longint'(cfg_start < cfg_length ? cfg_start : cfg_length);
      if (longint'(cfg_end) <= s + eps) e = longint'(cfg_length);
      else e = longint'(cfg_end < cfg_length ? cfg_end : cfg_length);
    end
    span = e - s;
    nxt = longint'(play_pos);
    prev = nxt < s ? s : (nxt > e ? e : nxt);
    if (act == ACT_RESTART) begin
      nxt = (cfg_rate < 0 && span > eps) ? e : s;
    end else if (!cfg_present || cfg_length == '0) begin
      nxt = 0;
    end else if (span <= eps) begin
      nxt = s;
    end else begin
      mag = longint'(cfg_rate);
      if (mag < 0) mag = -mag;
      d = (longint'(dt) * mag) >> RATE_FRAC_BITS;
      if (cfg_rate < 0) d = -d;
      raw = prev + d;
      if (cfg_looping) begin
        r.wrapped_forward  = (cfg_rate > 0) && (raw >= e);
        r.wrapped_backward = (cfg_rate < 0) && (raw < s);
        off = (raw - s) % span;
        if (off < 0) off += span;
        nxt = s + off;
      end else begin
        nxt = raw < s ? s : (raw > e ? e : raw);
      end
    end
    play_pos = nxt[POS_W-1:0];
    el = (nxt < s ? s : (nxt > e ? e : nxt)) - s;
    rem = span > el ? span - el : 0;
    r.previous_position  = prev[POS_W-1:0];
    r.new_position       = nxt[POS_W-1:0];
    r.effective_start    = s[POS_W-1:0];
    r.effective_end      = e[POS_W-1:0];
    r.elapsed_in_range   = el[POS_W-1:0];
    r.remaining_in_range = rem[POS_W-1:0];
    return r;
  endfunction

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] v);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= v;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (pready !== 1'b1);
    psel    <= 1'b0;
    penable <= 1'b0;
    apply_reg(idx, v);
    settings_done++;
    @(posedge clk_i);
  endtask

  // lower valid and wait until every expected beat has come back
  task automatic drain();
    in_if.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (2) @(posedge clk_i);
  endtask

  task automatic send_beat(input logic act, input logic [DELTA_W-1:0] dt, input bit known,
                           input lrpp_out_t known_res);
    int unsigned gap;
    lrpp_out_t pred;
    gap = pick_wait();
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.data  <= '{action: act, delta_time: dt};
    do @(posedge clk_i); while (in_if.ready !== 1'b1);
    pred = step_play_position(act, dt);
    if (pred.wrapped_forward) fwd_wraps++;
    if (pred.wrapped_backward) bwd_wraps++;
    if (act == ACT_RESTART) restarts_sent++;
    beats_sent++;
    pending_results.push_back(known ? known_res : pred);
  endtask

  function automatic logic [31:0] with_junk(input logic [31:0] v, input int unsigned w);
    logic [31:0] junk;
    junk = $urandom;
    return ($urandom_range(0, 3) == 0) ? (v | (junk << w)) : v;
  endfunction

  task automatic pick_setup();
    logic [31:0] len, st, en, rt;
    case ($urandom_range(0, 5))
      0: len = 0;
      1: len = $urandom_range(1, 64);
      2: len = $urandom_range(65, 100000);
      3: len = $urandom & 32'h7FFF_FFFF;
      4: len = 32'h7FFF_FFFF;
      default: len = $urandom_range(8, 4000);
    endcase
    case ($urandom_range(0, 4))
      0: st = 0;
      1: st = $urandom_range(0, len);
      2: st = len;
      3: st = $urandom & 32'h7FFF_FFFF;
      default: st = (len > 100) ? $urandom_range(0, len - 100) : 0;
    endcase
    case ($urandom_range(0, 4))
      0: en = 0;
      1: en = st + $urandom_range(0, 10);
      2: en = $urandom_range(st, len);
      3: en = $urandom;
      default: en = len;
    endcase
    case ($urandom_range(0, 6))
      0: rt = 32'h8000;
      1: rt = 32'h7FFF;
      2: rt = 0;
      3: rt = 32'h0100;
      4: rt = 32'hFF00;
      default: rt = $urandom & 32'hFFFF;
    endcase
    write_reg(REG_PRESENT, with_junk({31'd0, $urandom_range(0, 7) != 0}, 1));
    write_reg(REG_LENGTH, with_junk(len, POS_W));
    write_reg(REG_START, with_junk(st, POS_W));
    write_reg(REG_END, with_junk(en, POS_W));
    write_reg(REG_RATE, with_junk(rt, RATE_W));
    write_reg(REG_LOOPING, with_junk({31'd0, 1'($urandom_range(0, 1))}, 1));
  endtask

  task automatic cmp_field(input string name, input logic [31:0] e, input logic [31:0] g);
    if (e !== g) begin
      $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, e, g);
      err_count++;
    end
  endtask

  task automatic check_beat(input lrpp_out_t got);
    lrpp_out_t ex;
    if (pending_results.size() == 0) begin
      $display("%0t: result beat with nothing expected, actual %0h", $time, got);
      err_count++;
    end else begin
      ex = pending_results.pop_front();
      cmp_field("previous_position", ex.previous_position, got.previous_position);
      cmp_field("new_position", ex.new_position, got.new_position);
      cmp_field("wrapped_forward", ex.wrapped_forward, got.wrapped_forward);
      cmp_field("wrapped_backward", ex.wrapped_backward, got.wrapped_backward);
      cmp_field("effective_start", ex.effective_start, got.effective_start);
      cmp_field("effective_end", ex.effective_end, got.effective_end);
      cmp_field("elapsed_in_range", ex.elapsed_in_range, got.elapsed_in_range);
      cmp_field("remaining_in_range", ex.remaining_in_range, got.remaining_in_range);
    end
  endtask

  // result sink with random back-pressure
  initial begin
    int unsigned stall;
    out_if.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      stall = pick_wait();
      if (stall > 0) begin
        out_if.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_if.ready <= 1'b1;
      do @(posedge clk_i); while (out_if.valid !== 1'b1);
      check_beat(out_if.data);
    end
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("%0t: timeout, %0d beats still expected", $time, pending_results.size());
    $display("loop_range_play_position_tb NOT OK");
    $finish;
  end

  initial begin
    logic               act;
    logic [DELTA_W-1:0] dt;
    clk_i       = 1'b0;
    rst_ni      = 1'b0;
    psel        = 1'b0;
    penable     = 1'b0;
    pwrite      = 1'b0;
    paddr       = '0;
    pwdata      = '0;
    in_if.valid = 1'b0;
    in_if.data  = '0;
    cfg_present = 1'b0;
    cfg_length  = '0;
    cfg_start   = '0;
    cfg_end     = '0;
    cfg_rate    = RATE_RESET;
    cfg_looping = 1'b0;
    play_pos    = '0;
    no_gaps     = 1'b0;
    err_count   = 0;
    cycle_count = 0;
    beats_sent  = 0;
    restarts_sent = 0;
    settings_done = 0;
    fwd_wraps   = 0;
    bwd_wraps   = 0;

    dir_tab = '{
      known_row(ACT_ADVANCE, 21'h1FFFFF, ZERO_RES),
      known_row(ACT_RESTART, 21'h0, ZERO_RES),
      cfg_row(REG_PRESENT, 32'd1),
      known_row(ACT_ADVANCE, 21'h100000, ZERO_RES),
      cfg_row(REG_LENGTH, 32'd100),
      cfg_row(REG_START, 32'd100),
      known_row(ACT_ADVANCE, 21'h010000,
                mk_res(31'd100, 31'd100, 31'd100, 31'd100, 31'd0, 31'd0)),
      cfg_row(REG_START, 32'd0),
      cfg_row(REG_LENGTH, 32'h7FFF_FFFF),
      beat_row(ACT_ADVANCE, 21'h1FFFFF),
      cfg_row(REG_LOOPING, 32'd1),
      cfg_row(REG_END, 32'h0001_0000),
      beat_row(ACT_ADVANCE, 21'h1FFFFF),
      cfg_row(REG_RATE, 32'h8000),
      beat_row(ACT_ADVANCE, 21'h1FFFFF),
      beat_row(ACT_RESTART, 21'h0),
      cfg_row(REG_RATE, 32'h7FFF),
      beat_row(ACT_ADVANCE, 21'h1FFFFF),
      cfg_row(REG_RATE, 32'd0),
      beat_row(ACT_ADVANCE, 21'h1),
      cfg_row(REG_LOOPING, 32'd0),
      cfg_row(REG_RATE, 32'hFF00),
      beat_row(ACT_ADVANCE, 21'h1FFFFF),
      cfg_row(REG_START, 32'h7FFF_FFFF),
      cfg_row(REG_END, 32'h7FFF_FFFF),
      known_row(ACT_ADVANCE, 21'h0,
                mk_res(POS_MAX, POS_MAX, POS_MAX, POS_MAX, 31'd0, 31'd0)),
      known_row(ACT_RESTART, 21'h1FFFFF,
                mk_res(POS_MAX, POS_MAX, POS_MAX, POS_MAX, 31'd0, 31'd0)),
      cfg_row(REG_PRESENT, 32'd0),
      known_row(ACT_ADVANCE, 21'h5, ZERO_RES),
      cfg_row(REG_PRESENT, 32'd1),
      cfg_row(REG_LENGTH, 32'd1000),
      cfg_row(REG_START, 32'd10),
      cfg_row(REG_END, 32'd17),
      beat_row(ACT_ADVANCE, 21'h100),
      cfg_row(REG_END, 32'd18),
      cfg_row(REG_LOOPING, 32'd1),
      beat_row(ACT_ADVANCE, 21'h40),
      beat_row(ACT_RESTART, 21'h0),
      beat_row(ACT_ADVANCE, 21'h0),
      cfg_row(REG_RATE, 32'h0100),
      beat_row(ACT_ADVANCE, 21'h8)
    };

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < DIR_N; i++) begin
      if (dir_tab[i].cfg) begin
        drain();
        write_reg(dir_tab[i].reg_idx, dir_tab[i].wdata);
      end else begin
        send_beat(dir_tab[i].act, dir_tab[i].dt, dir_tab[i].known, dir_tab[i].res);
      end
    end

    for (int p = 0; p < RAND_PHASES; p++) begin
      drain();
      no_gaps = ($urandom_range(0, 3) == 0);
      pick_setup();
      for (int k = 0; k < PHASE_BEATS; k++) begin
        act = ($urandom_range(0, 7) == 0) ? ACT_RESTART : ACT_ADVANCE;
        case ($urandom_range(0, 5))
          0: dt = DELTA_W'($urandom_range(0, 16));
          1: dt = DELTA_W'($urandom_range(0, 32'h1_0000));
          2: dt = DELTA_W'($urandom);
          3: dt = 21'h1FFFFF;
          4: dt = 21'h100000;
          default: dt = DELTA_W'($urandom_range(0, 32'h4_0000));
        endcase
        send_beat(act, dt, 1'b0, ZERO_RES);
      end
    end

    drain();
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("covered %0d beats (%0d restarts) across %0d register writes",
             beats_sent, restarts_sent, settings_done);
    $display("predicted %0d forward and %0d backward loop wraps", fwd_wraps, bwd_wraps);
    if (err_count == 0) begin
      $display("loop_range_play_position_tb OK");
    end else begin
      $display("loop_range_play_position_tb NOT OK");
    end
    $finish;
  end

endmodule
